>>> sv/xmodem_crc_sender_assert.svh
// Assertion macros for the XMODEM-CRC sender.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef XMODEM_CRC_SENDER_ASSERT_SVH
`define XMODEM_CRC_SENDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xmodem_crc_sender: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define XCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xmodem_crc_sender: next-cycle check failed");

`endif

>>> sv/xcs_pkg.sv
// Shared types, codes and the CRC-16 step for the XMODEM-CRC sender.
// No dependencies.
`default_nettype none

package xcs_pkg;

  localparam logic [7:0] MarkSoh = 8'h01;
  localparam logic [7:0] MarkEot = 8'h04;
  localparam logic [7:0] MarkAck = 8'h06;
  localparam logic [7:0] MarkNak = 8'h15;
  localparam logic [7:0] DefaultPad = 8'h1A;
  localparam logic [7:0] DefaultTimeout = 8'd200;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam int unsigned DefaultQueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_PAYLOAD = 3'd1,
    CMD_PAD     = 3'd2,
    CMD_REPLY   = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_SENDING     = 4'd1,
    ST_WAIT_BLOCK  = 4'd2,
    ST_WAIT_LAST   = 4'd3,
    ST_WAIT_NAK    = 4'd4,
    ST_WAIT_FINAL  = 4'd5,
    ST_DONE        = 4'd6,
    ST_REPLY_ABORT = 4'd7,
    ST_TIME_ABORT  = 4'd8,
    ST_REJECT      = 4'd9
  } status_e;

  // One queued item: one or three result bytes sharing valid and status.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       three;
    logic       tx_valid;
    status_e    status;
  } entry_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/xcs_front.sv
// Front end: accepts commands, keeps the protocol state and the CRC,
// and queues one entry per command. Depends on xcs_pkg.
`default_nettype none

module xcs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [2:0]      command_i,
  input  logic [7:0]      payload_byte_i,
  input  logic [7:0]      reply_byte_i,
  input  logic [7:0]      timeout_limit_i,
  input  logic [7:0]      pad_value_i,
  output xcs_pkg::entry_t entry_o
);
  import xcs_pkg::*;

  status_e     phase_q, phase_d;
  logic [7:0]  pkt_q, pkt_d;
  logic [6:0]  fill_q, fill_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  ticks_q, ticks_d;

  logic        restartable;
  logic        in_wait;
  logic [7:0]  data_byte;
  logic [15:0] crc_next;
  logic [8:0]  ticks_inc;

  assign restartable = (phase_q == ST_IDLE) || (phase_q == ST_DONE) ||
                       (phase_q == ST_REPLY_ABORT) || (phase_q == ST_TIME_ABORT);
  assign in_wait = (phase_q == ST_WAIT_BLOCK) || (phase_q == ST_WAIT_LAST) ||
                   (phase_q == ST_WAIT_NAK) || (phase_q == ST_WAIT_FINAL);
  assign data_byte = (command_i == CMD_PAYLOAD) ? payload_byte_i : pad_value_i;
  assign crc_next  = crc_feed(crc_q, data_byte);
  assign ticks_inc = {1'b0, ticks_q} + 9'd1;

  always_comb begin
    phase_d = phase_q;
    pkt_d   = pkt_q;
    fill_d  = fill_q;
    crc_d   = crc_q;
    ticks_d = ticks_q;
    entry_o = '{b0: 8'h00, b1: 8'h00, b2: 8'h00, three: 1'b0,
                tx_valid: 1'b0, status: ST_REJECT};
    unique case (command_i)
      CMD_START: begin
        if (restartable) begin
          phase_d = ST_SENDING;
          pkt_d   = 8'd1;
          fill_d  = '0;
          crc_d   = '0;
          ticks_d = '0;
          entry_o = '{b0: MarkSoh, b1: 8'd1, b2: 8'hFE, three: 1'b1,
                      tx_valid: 1'b1, status: ST_SENDING};
        end
      end
      CMD_PAYLOAD, CMD_PAD: begin
        if (phase_q == ST_SENDING) begin
          crc_d  = crc_next;
          fill_d = fill_q + 7'd1;
          entry_o.b0       = data_byte;
          entry_o.tx_valid = 1'b1;
          entry_o.status   = ST_SENDING;
          // The byte that fills the block carries the CRC behind it.
          if (fill_q == 7'h7F) begin
            phase_d = (command_i == CMD_PAYLOAD) ? ST_WAIT_BLOCK : ST_WAIT_LAST;
            ticks_d = '0;
            entry_o.b1     = crc_next[15:8];
            entry_o.b2     = crc_next[7:0];
            entry_o.three  = 1'b1;
            entry_o.status = phase_d;
          end
        end
      end
      CMD_REPLY: begin
        if (in_wait) begin
          if (phase_q == ST_WAIT_BLOCK && reply_byte_i == MarkAck) begin
            pkt_d   = pkt_q + 8'd1;
            crc_d   = '0;
            fill_d  = '0;
            phase_d = ST_SENDING;
            entry_o = '{b0: MarkSoh, b1: pkt_d, b2: ~pkt_d, three: 1'b1,
                        tx_valid: 1'b1, status: ST_SENDING};
          end else if ((phase_q == ST_WAIT_LAST && reply_byte_i == MarkAck) ||
                       (phase_q == ST_WAIT_NAK && reply_byte_i == MarkNak)) begin
            phase_d = (phase_q == ST_WAIT_LAST) ? ST_WAIT_NAK : ST_WAIT_FINAL;
            ticks_d = '0;
            entry_o.b0       = MarkEot;
            entry_o.tx_valid = 1'b1;
            entry_o.status   = phase_d;
          end else if (phase_q == ST_WAIT_FINAL && reply_byte_i == MarkAck) begin
            phase_d        = ST_DONE;
            entry_o.status = ST_DONE;
          end else begin
            phase_d        = ST_REPLY_ABORT;
            entry_o.status = ST_REPLY_ABORT;
          end
        end
      end
      CMD_TICK: begin
        if (in_wait) begin
          if (ticks_inc > {1'b0, timeout_limit_i}) begin
            phase_d = ST_TIME_ABORT;
          end else begin
            ticks_d = ticks_inc[7:0];
          end
        end
        entry_o.status = phase_d;
      end
      default: begin
        entry_o.status = ST_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ST_IDLE;
      pkt_q   <= '0;
      fill_q  <= '0;
      crc_q   <= '0;
      ticks_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pkt_q   <= pkt_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/xcs_fifo.sv
// Short queue of entries between the front end and the serializer.
// Depends on xcs_pkg.
`default_nettype none

module xcs_fifo #(
  parameter int unsigned Depth = xcs_pkg::DefaultQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  xcs_pkg::entry_t wr_data_i,
  input  logic            rd_i,
  output xcs_pkg::entry_t rd_data_o,
  output logic            full_o,
  output logic            empty_o
);
  import xcs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/xcs_back.sv
// Back end: serializes each queued entry into one or three results held
// in an output register. Depends on xcs_pkg.
`default_nettype none

module xcs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xcs_pkg::entry_t  entry_i,
  input  logic             avail_i,
  output logic             take_o,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       tx_byte_o,
  output logic             tx_valid_o,
  output logic [3:0]       status_o,
  output logic             last_result_o
);
  import xcs_pkg::*;

  logic       out_valid_q;
  logic [1:0] idx_q;
  logic [7:0] byte_q;
  logic       txv_q, last_q;
  logic [3:0] status_q;

  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  // The output register can take a new result when it is free or being popped.
  assign load    = !out_valid_q || pop;
  assign is_last = !entry_i.three || (idx_q == 2'd2);
  assign take_o  = load && avail_i && is_last;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = entry_i.b0;
      2'd1:    sel_byte = entry_i.b1;
      default: sel_byte = entry_i.b2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= avail_i;
      if (avail_i) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && avail_i) begin
      byte_q   <= sel_byte;
      txv_q    <= entry_i.tx_valid;
      status_q <= entry_i.status;
      last_q   <= is_last;
    end
  end

  assign empty         = !out_valid_q;
  assign tx_byte_o     = byte_q;
  assign tx_valid_o    = txv_q;
  assign status_o      = status_q;
  assign last_result_o = last_q;

endmodule

`default_nettype wire

>>> sv/xmodem_crc_sender.sv
// XMODEM-CRC sender, 128-byte blocks, top level with APB register port.
// The first result of a command passes through the queue and then the output register
// on its way to the outputs, if the result queue is drained.
// Throughput: one command per cycle for single-result commands while results are popped;
// a header or CRC command occupies the output register for three results.
// Reset: asynchronous and active low; state idle, timeout 200, pad byte 0x1A.
`default_nettype none

module xmodem_crc_sender #(
  parameter int unsigned QueueDepth = xcs_pkg::DefaultQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [7:0]  reply_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte_o,
  output logic        tx_valid_o,
  output logic [3:0]  status_o,
  output logic        last_result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xcs_pkg::*;
  `include "xmodem_crc_sender_assert.svh"

  logic [7:0] timeout_q, pad_q;
  logic       accept;
  logic       q_empty, q_take;
  entry_t     front_entry, q_entry;

  assign pready = 1'b1;
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= DefaultTimeout;
      pad_q     <= DefaultPad;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        pad_q <= pwdata[7:0];
      end else begin
        timeout_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = {24'h000000, paddr[2] ? pad_q : timeout_q};

  xcs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .payload_byte_i (payload_byte_i),
    .reply_byte_i   (reply_byte_i),
    .timeout_limit_i(timeout_q),
    .pad_value_i    (pad_q),
    .entry_o        (front_entry)
  );

  xcs_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_data_i(front_entry),
    .rd_i     (q_take),
    .rd_data_o(q_entry),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  xcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (q_entry),
    .avail_i      (!q_empty),
    .take_o       (q_take),
    .pop          (pop),
    .empty        (empty),
    .tx_byte_o    (tx_byte_o),
    .tx_valid_o   (tx_valid_o),
    .status_o     (status_o),
    .last_result_o(last_result_o)
  );

  // A transferred command always leaves an entry in the queue.
  `XCS_ASSERT_NEXT(a_push_fills_queue, accept, !q_empty)
  // Rejected commands produce exactly one result.
  `XCS_ASSERT_NOW(a_reject_single, !empty && status_o == ST_REJECT, last_result_o)
  // Only headers and CRC blocks give several results, and those are all bytes.
  `XCS_ASSERT_NOW(a_multi_is_data, !empty && !last_result_o, tx_valid_o)

endmodule

`default_nettype wire
